// ===== rtl/ntc_pkg.sv =====
// Shared constants, types and the resistance table for the NTC linearizer.
// Used by ntc_ctrl, ntc_dp and ntc_thermistor_linearizer; no dependencies.
package ntc_pkg;

    // Converter resolution and field widths
    localparam int ADC_BITS  = 10;
    localparam int IN_W      = 16;          // s_tdata width (adc_sample padded)
    localparam int TEMP_W    = 15;
    localparam int OUT_W     = 16;          // m_tdata width (temp_centi padded)
    localparam int STAT_W    = 2;
    localparam int OFF_W     = 14;

    // Shared restoring divider
    localparam int DIV_W     = 31;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    // Resistance table, 10-ohm units, 0..100 C in 5 C steps
    localparam int RES_W     = 16;
    localparam int TBL_LEN   = 21;
    localparam int IDX_W     = $clog2(TBL_LEN);
    localparam int FRAC_W    = 9;           // interpolation fraction stays below 500
    localparam int BASE_W    = 14;          // index times step, up to 10000

    localparam logic [DIV_W-1:0] DIVIDEND_Q = DIV_W'(((2 ** ADC_BITS) - 1) * 100000);
    localparam logic [DIV_W-1:0] DIV_NUM    = DIV_W'(1200000000);
    localparam logic [DIV_W-1:0] SCALE      = DIV_W'(100000);
    localparam logic [BASE_W-1:0] STEP_CENTI = BASE_W'(500);
    localparam logic [RES_W-1:0] RES_MAX    = '1;

    localparam logic signed [TEMP_W:0] OUT_MIN = -(TEMP_W+1)'(16384);
    localparam logic signed [TEMP_W:0] OUT_MAX = (TEMP_W+1)'(16383);

    localparam logic [RES_W-1:0] RES_TABLE [0:TBL_LEN-1] = '{
        16'd34090, 16'd26310, 16'd20440, 16'd16000, 16'd12610, 16'd10000,
        16'd7981,  16'd6408,  16'd5174,  16'd4202,  16'd3431,  16'd2816,
        16'd2322,  16'd1925,  16'd1603,  16'd1340,  16'd1126,  16'd949,
        16'd804,   16'd684,   16'd0
    };

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BELOW   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Operand sets for the shared divider
    typedef enum logic [1:0] {
        DIV_Q,      // full scale * 100000 / adc
        DIV_R,      // 1200000000 / (q - 100000)
        DIV_F       // (r - lo) * 500 / (hi - lo)
    } div_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_Q,
        S_DIV_R,
        S_SRCH,
        S_START_F,
        S_DIV_F,
        S_FIN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_adc;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_r;
        logic     search;
        logic     finish;
    } ntc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bad;
        logic below;
        logic div_done;
        logic out_free;
    } ntc_stat_t;

endpackage

// ===== rtl/ntc_ctrl.sv =====
// Sequencing state machine for the NTC linearizer.
// Depends on ntc_pkg; drives ntc_dp through ntc_cmd_t and reads ntc_stat_t.
module ntc_ctrl
    import ntc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ntc_stat_t stat,
    output ntc_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.bad ? S_FIN : S_DIV_Q;
            end
            S_DIV_Q:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                if (stat.div_done)
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                state_next = (stat.bad || stat.below) ? S_FIN : S_START_F;
            end
            S_START_F:
            begin
                state_next = S_DIV_F;
            end
            S_DIV_F:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd       = '0;
        cmd.div_sel = DIV_Q;
        s_tready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load_adc = s_tvalid;
            end
            S_CHECK:
            begin
                cmd.div_start = !stat.bad;
                cmd.div_sel   = DIV_Q;
            end
            S_DIV_Q:
            begin
                cmd.div_start = stat.div_done;
                cmd.div_sel   = DIV_R;
            end
            S_DIV_R:
            begin
                cmd.take_r = stat.div_done;
            end
            S_SRCH:
            begin
                cmd.search = 1'b1;
            end
            S_START_F:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_F;
            end
            S_FIN:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ntc_dp.sv =====
// Datapath of the NTC linearizer: sample and offset registers, shared
// restoring divider, table search, interpolation and the output register.
// Depends on ntc_pkg; commanded by ntc_ctrl.
module ntc_dp
    import ntc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                cfg_valid,
    input  logic [OFF_W-1:0]    cfg_data,
    input  ntc_cmd_t            cmd,
    output ntc_stat_t           stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic [STAT_W-1:0]   m_tuser
);

    logic [ADC_BITS-1:0]  adc_reg;
    logic                 bad_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [RES_W-1:0]     r_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic                 out_valid_reg;
    logic [TEMP_W-1:0]    temp_reg;
    status_t              status_reg;

    logic [ADC_BITS-1:0]  adc_in;
    logic [DIV_W-1:0]     den;
    logic [DIV_W:0]       shifted;
    logic [DIV_W+1:0]     diff;
    logic [DIV_W-1:0]     ld_dividend;
    logic [DIV_W-1:0]     ld_divisor;
    logic [RES_W-1:0]     tbl_lo;
    logic [RES_W-1:0]     tbl_hi;
    logic [DIV_W-1:0]     num_f;
    logic                 below;
    logic [BASE_W-1:0]    base;
    logic [BASE_W-1:0]    temp_raw;
    logic signed [TEMP_W:0] temp_off;
    logic [TEMP_W-1:0]    temp_sat;
    status_t              status_new;

    // Calibration offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            offset_reg <= cfg_data;
        end
    end

    // Sample capture and invalid flag
    assign adc_in = s_tdata[ADC_BITS-1:0];
    assign den    = quo_reg - SCALE;

    always_ff @(posedge clk)
    begin
        if (cmd.load_adc)
        begin
            adc_reg <= adc_in;
            bad_reg <= (adc_in == '0) || (adc_in == '1);
        end
        else if (cmd.div_start && cmd.div_sel == DIV_R && den == '0)
        begin
            bad_reg <= 1'b1;
        end
    end

    // Interpolation operands from the table
    assign tbl_lo = RES_TABLE[idx_reg];
    assign tbl_hi = RES_TABLE[idx_reg - IDX_W'(1)];
    assign num_f  = DIV_W'((r_reg - tbl_lo) * 25'(500));

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_Q:
            begin
                ld_dividend = DIVIDEND_Q;
                ld_divisor  = DIV_W'(adc_reg);
            end
            DIV_R:
            begin
                ld_dividend = DIV_NUM;
                ld_divisor  = den;
            end
            DIV_F:
            begin
                ld_dividend = num_f;
                ld_divisor  = DIV_W'(tbl_hi - tbl_lo);
            end
            default:
            begin
                ld_dividend = '0;
                ld_divisor  = '0;
            end
        endcase
    end

    // One restoring step: shift in the next dividend bit, trial subtract
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            cnt_reg <= CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= ld_dividend;
            dvs_reg <= ld_divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (diff[DIV_W+1])
            begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= diff[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
        end
    end

    // Resistance, saturated to 16 bits
    always_ff @(posedge clk)
    begin
        if (cmd.take_r)
        begin
            r_reg <= (|quo_reg[DIV_W-1:RES_W]) ? RES_MAX : quo_reg[RES_W-1:0];
        end
    end

    // Table search: first entry from index 1 not above r (last entry is 0)
    always_comb
    begin
        idx_next = IDX_W'(1);
        for (int k = 1; k < TBL_LEN - 1; k++)
        begin
            if (RES_TABLE[k] > r_reg)
            begin
                idx_next = IDX_W'(k + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            idx_reg <= idx_next;
        end
    end

    assign below = r_reg > RES_TABLE[0];

    // Result: interpolate, subtract offset, saturate
    assign base     = BASE_W'(idx_reg) * STEP_CENTI;
    assign temp_raw = below ? '0 : (base - BASE_W'(quo_reg[FRAC_W-1:0]));
    assign temp_off = $signed({2'b00, temp_raw}) - $signed({{2{offset_reg[OFF_W-1]}}, offset_reg});

    always_comb
    begin
        if (temp_off < OUT_MIN)
        begin
            temp_sat = OUT_MIN[TEMP_W-1:0];
        end
        else if (temp_off > OUT_MAX)
        begin
            temp_sat = OUT_MAX[TEMP_W-1:0];
        end
        else
        begin
            temp_sat = temp_off[TEMP_W-1:0];
        end

        if (bad_reg)
        begin
            status_new = ST_INVALID;
        end
        else if (below)
        begin
            status_new = ST_BELOW;
        end
        else
        begin
            status_new = ST_OK;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            temp_reg   <= bad_reg ? '0 : temp_sat;
            status_reg <= status_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(temp_reg);
    assign m_tuser  = status_reg;

    // Status to controller
    assign stat.bad      = bad_reg;
    assign stat.below    = below;
    assign stat.div_done = (cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Divider is never restarted while it is iterating
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> cnt_reg == '0)
        else $error("divider restarted while busy");

    // A result is only loaded when the output register can take it
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // Interpolation fraction stays below one table step
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !bad_reg && !below) |-> quo_reg < DIV_W'(500))
        else $error("interpolation fraction out of range");

    // Invalid samples always report zero temperature
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_INVALID) |-> temp_reg == '0)
        else $error("invalid sample with nonzero temperature");

endmodule

// ===== rtl/ntc_thermistor_linearizer.sv =====
// Top level of the NTC thermistor linearizer.
// Depends on ntc_pkg, ntc_ctrl and ntc_dp.
//
// Usage:
//   Input stream (s_*): one 10-bit ADC reading of the thermistor divider per
//   transfer. Output stream (m_*): one temperature in hundredths of a degree
//   C per input, with a status code on m_tuser (0 ok, 1 colder than the
//   table so clamped to 0 C, 2 reading at 0 or full scale, temperature 0).
//   Config channel (cfg_*): writes the signed 14-bit calibration offset that
//   is subtracted from each non-invalid result; always ready, write while idle.
// Processing:
//   A reading is worked through one shared radix-2 restoring divider, one
//   quotient bit per cycle, 31 steps per division. A normal reading takes
//   three divisions; a reading colder than the table takes two; an invalid
//   reading none. One reading is in flight at a time; s_tready is high only
//   when idle, so the next reading is not taken until the last one is done.
// Reset: clears the offset to 0, the controller to idle and the output valid.
// Stall: a finished result waits in the output register; the next reading is
//   accepted and processed meanwhile, and its result waits until m_tready.
module ntc_thermistor_linearizer
    import ntc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,    // [9:0] adc_sample, rest unused
    // Output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,    // [14:0] temp_centi, [15] zero
    output logic [STAT_W-1:0]   m_tuser,    // [1:0] status
    // Offset write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [OFF_W-1:0]    cfg_data    // [13:0] temp_offset
);

    ntc_cmd_t  cmd;
    ntc_stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    ntc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic and output register
    ntc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== tb/sv/ntc_thermistor_linearizer_test.sv =====
// Self-checking testbench for ntc_thermistor_linearizer: streams ADC readings,
// predicts temperature and status for each one and checks every output transfer.
// Depends on ntc_pkg and the ntc_thermistor_linearizer RTL.
module ntc_thermistor_linearizer_test;
    import ntc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int STALL_LIMIT   = 4000;    // cycles with no transfer at all
    localparam int SETTLE_CYCLES = 110;     // about one full conversion
    localparam int PHASE_ITEMS   = 533;     // three random phases, ~1600 readings
    localparam int ADC_FULL      = (1 << ADC_BITS) - 1;
    localparam int TABLE_PTS     = 21;
    localparam int STEP          = 500;     // hundredths of a degree per table step
    localparam int TEMP_LO       = -16384;
    localparam int TEMP_HI       = 16383;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 14'h1fff;
    localparam logic [OFF_W-1:0] OFFSET_MIN = 14'h2000;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        status_t           status;
    } reading_t;

    // Thermistor resistance in 10-ohm units at 0, 5, ... 100 C
    int ohms_at [TABLE_PTS] = '{
        34090, 26310, 20440, 16000, 12610, 10000, 7981, 6408, 5174, 4202,
        3431, 2816, 2322, 1925, 1603, 1340, 1126, 949, 804, 684, 0
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [OFF_W-1:0]    cfg_data  = '0;

    int       src_idle_pct  = 13;
    int       sink_idle_pct = 88;
    int       cur_offset    = 0;
    int       errors        = 0;
    int       quiet_cycles  = 0;
    reading_t expected_readings [$];

    always #HALF_PERIOD clk = ~clk;

    ntc_thermistor_linearizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Reading -> resistance -> table interpolation -> offset and saturation
    function automatic reading_t convert_reading(input logic [ADC_BITS-1:0] adc,
                                                 input int offset);
        longint unsigned q;
        longint unsigned den;
        longint unsigned res;
        int              k;
        int              frac;
        int              temp;
        reading_t        rd;
        rd.status = ST_OK;
        rd.temp   = '0;
        if (adc == 0 || adc == ADC_FULL)
        begin
            rd.status = ST_INVALID;
            return rd;
        end
        q   = 64'(ADC_FULL) * 64'd100000 / 64'(adc);
        den = q - 64'd100000;
        if (den == 0)
        begin
            rd.status = ST_INVALID;
            return rd;
        end
        res = 64'd1200000000 / den;
        if (res > 64'd65535)
            res = 64'd65535;
        if (res > 64'(ohms_at[0]))
        begin
            temp      = 0;
            rd.status = ST_BELOW;
        end
        else if (res == 64'(ohms_at[0]))
            temp = 0;
        else
        begin
            // first entry not above the resistance, then interpolate back
            k = 1;
            while (k < TABLE_PTS - 1 && 64'(ohms_at[k]) > res)
                k++;
            frac = int'(((res - 64'(ohms_at[k])) * 64'd500)
                        / 64'(ohms_at[k-1] - ohms_at[k]));
            temp = k * STEP - frac;
        end
        temp = temp - offset;
        if (temp < TEMP_LO)
            temp = TEMP_LO;
        else if (temp > TEMP_HI)
            temp = TEMP_HI;
        rd.temp = temp[TEMP_W-1:0];
        return rd;
    endfunction

    // Mostly uniform, with extra weight on the invalid edges and the cold limit
    function automatic logic [ADC_BITS-1:0] random_adc();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0)
            return (ADC_BITS)'($urandom_range(2, 0));
        else if (pick == 1)
            return (ADC_BITS)'(ADC_FULL - $urandom_range(2, 0));
        else if (pick == 2)
            return (ADC_BITS)'($urandom_range(775, 740));
        return (ADC_BITS)'($urandom_range(ADC_FULL, 0));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // Entered and left just after a falling edge
    task automatic send_sample(input logic [ADC_BITS-1:0] adc);
        while (roll(src_idle_pct))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(adc);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_readings.push_back(convert_reading(adc, cur_offset));
        @(negedge clk);
    endtask

    task automatic write_offset(input logic [OFF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_offset = int'($signed(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Block is idle once every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic test_directed_readings();
        logic [ADC_BITS-1:0] adcs [$];
        adcs = '{10'd0, 10'd1, 10'd2, 10'd100, 10'd500, 10'd511, 10'd512, 10'd700,
                 10'd740, 10'd756, 10'd757, 10'd800, 10'd1000, 10'd1021, 10'd1022,
                 10'd1023, 10'h155, 10'h2aa};
        foreach (adcs[n])
            send_sample(adcs[n]);
    endtask

    // Offset at both ends of its field, saturating the output high
    task automatic test_offset_extremes();
        wait_drained();
        write_offset(OFFSET_MAX);
        send_sample(10'd1);
        send_sample(10'd400);
        send_sample(10'd900);
        wait_drained();
        write_offset(OFFSET_MIN);
        send_sample(10'd1);
        send_sample(10'd400);
        send_sample(10'd1023);
    endtask

    task automatic test_random_readings(input int src_pct, input int sink_pct,
                                        input int offset, input int count);
        logic [OFF_W-1:0] raw;
        raw = offset[OFF_W-1:0];
        wait_drained();
        write_offset(raw);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count)
            send_sample(random_adc());
    endtask

    // Receiver backpressure
    always @(negedge clk)
        m_tready <= !roll(sink_idle_pct);

    // Result checking and watchdog
    always @(posedge clk)
    begin : check_results
        reading_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_readings.size() == 0)
                report_mismatch($sformatf("unexpected result temp=%0d status=%0d",
                                          $signed(m_tdata[TEMP_W-1:0]), m_tuser));
            else
            begin
                want = expected_readings.pop_front();
                if (m_tdata[TEMP_W-1:0] !== want.temp)
                    report_mismatch($sformatf("temp_centi got %0d want %0d",
                                              $signed(m_tdata[TEMP_W-1:0]),
                                              $signed(want.temp)));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, want.status));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_readings();
        test_offset_extremes();
        test_random_readings(13, 88, $urandom_range(10000, 0) - 5000, PHASE_ITEMS);
        test_random_readings(88, 13, 5000, PHASE_ITEMS);
        test_random_readings(0, 0, -5000, PHASE_ITEMS);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ntc_pkg.sv
rtl/ntc_ctrl.sv
rtl/ntc_dp.sv
rtl/ntc_thermistor_linearizer.sv
tb/sv/ntc_thermistor_linearizer_test.sv
